FILE: sv/rtnh_pkg.sv
// Shared types, constants and fixed-point helpers for the ray/triangle nearest-hit unit.
// No dependencies; every other file imports this package.
package rtnh_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_TRI   = 16;
	localparam int SLOT_W    = 4;
	localparam int CNT_W     = 5;
	localparam int DIV_W     = 32 + FRAC_BITS;
	localparam int DCNT_W    = $clog2(DIV_W);
	localparam int WK_AW     = 5;
	localparam int NUM_UOPS  = 24;

	localparam logic [1:0] ACT_VERTEX   = 2'd0;
	localparam logic [1:0] ACT_MATERIAL = 2'd1;
	localparam logic [1:0] ACT_CAST     = 2'd2;
	localparam logic [1:0] CORNER_LAST  = 2'd2;

	typedef logic signed [31:0] fx_t;
	typedef struct packed {
		fx_t x;
		fx_t y;
		fx_t z;
	} vec_t;
	typedef vec_t [2:0] vrow_t;
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       refl;
	} mat_t;
	typedef struct packed {
		logic              vert_we;
		logic              mat_we;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        corner;
		vec_t              vtx;
		mat_t              mat;
	} store_wr_t;

	// Scratch memory map for one triangle.
	localparam logic [WK_AW-1:0] WK_A   = 5'd0;
	localparam logic [WK_AW-1:0] WK_B   = 5'd1;
	localparam logic [WK_AW-1:0] WK_C   = 5'd2;
	localparam logic [WK_AW-1:0] WK_D   = 5'd3;
	localparam logic [WK_AW-1:0] WK_E   = 5'd4;
	localparam logic [WK_AW-1:0] WK_F   = 5'd5;
	localparam logic [WK_AW-1:0] WK_J   = 5'd6;
	localparam logic [WK_AW-1:0] WK_K   = 5'd7;
	localparam logic [WK_AW-1:0] WK_L   = 5'd8;
	localparam logic [WK_AW-1:0] WK_GX  = 5'd9;
	localparam logic [WK_AW-1:0] WK_GY  = 5'd10;
	localparam logic [WK_AW-1:0] WK_GZ  = 5'd11;
	localparam logic [WK_AW-1:0] WK_EI  = 5'd12;
	localparam logic [WK_AW-1:0] WK_GF  = 5'd13;
	localparam logic [WK_AW-1:0] WK_DH  = 5'd14;
	localparam logic [WK_AW-1:0] WK_AK  = 5'd15;
	localparam logic [WK_AW-1:0] WK_JC  = 5'd16;
	localparam logic [WK_AW-1:0] WK_BL  = 5'd17;
	localparam logic [WK_AW-1:0] WK_DET = 5'd18;
	localparam logic [WK_AW-1:0] WK_TN  = 5'd19;
	localparam logic [WK_AW-1:0] WK_GN  = 5'd20;
	localparam logic [WK_AW-1:0] WK_BN  = 5'd21;

	localparam logic [2:0] OP_FIRST = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_SUB   = 3'd2;
	localparam logic [2:0] OP_ADDW  = 3'd3;
	localparam logic [2:0] OP_ADDN  = 3'd4;

	typedef struct packed {
		logic [WK_AW-1:0] a;
		logic [WK_AW-1:0] b;
		logic [2:0]       mode;
		logic [WK_AW-1:0] dst;
	} uop_t;

	function automatic uop_t uop(input logic [4:0] k);
		uop_t u;
		u = '{WK_A, WK_A, OP_FIRST, WK_A};
		case (k)
			5'd0:  u = '{WK_E,  WK_GZ, OP_FIRST, WK_EI};
			5'd1:  u = '{WK_GY, WK_F,  OP_SUB,   WK_EI};
			5'd2:  u = '{WK_GX, WK_F,  OP_FIRST, WK_GF};
			5'd3:  u = '{WK_D,  WK_GZ, OP_SUB,   WK_GF};
			5'd4:  u = '{WK_D,  WK_GY, OP_FIRST, WK_DH};
			5'd5:  u = '{WK_E,  WK_GX, OP_SUB,   WK_DH};
			5'd6:  u = '{WK_A,  WK_K,  OP_FIRST, WK_AK};
			5'd7:  u = '{WK_J,  WK_B,  OP_SUB,   WK_AK};
			5'd8:  u = '{WK_J,  WK_C,  OP_FIRST, WK_JC};
			5'd9:  u = '{WK_A,  WK_L,  OP_SUB,   WK_JC};
			5'd10: u = '{WK_B,  WK_L,  OP_FIRST, WK_BL};
			5'd11: u = '{WK_K,  WK_C,  OP_SUB,   WK_BL};
			5'd12: u = '{WK_A,  WK_EI, OP_FIRST, WK_DET};
			5'd13: u = '{WK_B,  WK_GF, OP_ADD,   WK_DET};
			5'd14: u = '{WK_C,  WK_DH, OP_ADDW,  WK_DET};
			5'd15: u = '{WK_F,  WK_AK, OP_FIRST, WK_TN};
			5'd16: u = '{WK_E,  WK_JC, OP_ADD,   WK_TN};
			5'd17: u = '{WK_D,  WK_BL, OP_ADDN,  WK_TN};
			5'd18: u = '{WK_GZ, WK_AK, OP_FIRST, WK_GN};
			5'd19: u = '{WK_GY, WK_JC, OP_ADD,   WK_GN};
			5'd20: u = '{WK_GX, WK_BL, OP_ADDW,  WK_GN};
			5'd21: u = '{WK_J,  WK_EI, OP_FIRST, WK_BN};
			5'd22: u = '{WK_K,  WK_GF, OP_ADD,   WK_BN};
			5'd23: u = '{WK_L,  WK_DH, OP_ADDW,  WK_BN};
			default: u = '{WK_A, WK_A, OP_FIRST, WK_A};
		endcase
		return u;
	endfunction

	localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
	localparam fx_t FX_MIN = 32'sh8000_0000;
	localparam fx_t FX_ONE = fx_t'(1) <<< FRAC_BITS;

	function automatic fx_t sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? FX_MIN : FX_MAX;
		end
		return v[31:0];
	endfunction

	function automatic fx_t fadd(input fx_t a, input fx_t b);
		return sat33({a[31], a} + {b[31], b});
	endfunction

	function automatic fx_t fsub(input fx_t a, input fx_t b);
		return sat33({a[31], a} - {b[31], b});
	endfunction

	function automatic fx_t fneg(input fx_t a);
		return sat33(-{a[31], a});
	endfunction

	// Floor shift of a full product, then saturation to 32 bits.
	function automatic fx_t fmul_fin(input logic signed [63:0] p);
		logic signed [63:0] sh;
		sh = p >>> FRAC_BITS;
		if ((&sh[63:31]) || !(|sh[63:31])) begin
			return sh[31:0];
		end
		return sh[63] ? FX_MIN : FX_MAX;
	endfunction

	function automatic logic [7:0] to_channel(input fx_t v);
		fx_t q;
		q = v >>> FRAC_BITS;
		if (q < 0) begin
			return 8'd0;
		end
		if (q > 32'sd255) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

endpackage

FILE: sv/ray_triangle_nearest_hit_unit.sv
// Nearest ray/triangle hit by Cramer's rule in saturating Q16.16.
// A cast tests N triangles in turn:
// each triangle runs 24 multiply steps through one shared multiplier and scratch memory,
// then three 48-step serial divisions; a zero determinant ends it before the divisions.
// One cast at a time; busy is high until the result strobe. Results cannot be stalled.
// Reset clears control state and triangle_count; the stores hold garbage until written.
module ray_triangle_nearest_hit_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [4:0]          cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic [3:0]          tri_slot,
	input  logic [1:0]          vertex_sel,
	input  logic signed [31:0]  a_x,
	input  logic signed [31:0]  a_y,
	input  logic signed [31:0]  a_z,
	input  logic signed [31:0]  dir_x,
	input  logic signed [31:0]  dir_y,
	input  logic signed [31:0]  dir_z,
	input  logic                mirror_flag,
	output logic                done,
	output logic                hit,
	output logic [30:0]         hit_distance,
	output logic [3:0]          hit_slot,
	output logic [7:0]          color_r,
	output logic [7:0]          color_g,
	output logic [7:0]          color_b,
	output logic                hit_reflective
);
	import rtnh_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ROW  = 4'd1;
	localparam logic [3:0] ST_INIT = 4'd2;
	localparam logic [3:0] ST_OP   = 4'd3;
	localparam logic [3:0] ST_DRD  = 4'd4;
	localparam logic [3:0] ST_DST  = 4'd5;
	localparam logic [3:0] ST_DWT  = 4'd6;
	localparam logic [3:0] ST_CHK  = 4'd7;
	localparam logic [3:0] ST_MAT  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  tc_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  tri_q;
	logic [3:0]        init_q;
	logic [4:0]        op_q;
	logic [1:0]        ph_q;
	logic [1:0]        dk_q;
	vec_t              org_q;
	vec_t              dir_q;
	fx_t               acc_q;
	logic signed [63:0] p_q;
	fx_t               t_q;
	fx_t               g_q;
	fx_t               b_q;
	fx_t               best_q;
	logic [SLOT_W-1:0] bslot_q;
	logic              found_q;
	logic              done_q;
	logic              hit_q;
	logic [30:0]       dist_q;
	logic [3:0]        slot_q;
	mat_t              mat_q;

	// Scratch memory holding one triangle's operands and partial results.
	fx_t               wk_mem [2**WK_AW];
	fx_t               ra_q;
	fx_t               rb_q;
	logic [WK_AW-1:0]  ra_addr;
	logic [WK_AW-1:0]  rb_addr;
	logic              wk_we;
	logic [WK_AW-1:0]  wk_waddr;
	fx_t               wk_wdata;

	store_wr_t         swr;
	logic              v_re;
	vrow_t             v_rdata;
	logic              m_re;
	mat_t              m_rdata;
	uop_t              u;
	fx_t               fm;
	fx_t               sum;
	logic              div_start;
	logic              div_done;
	fx_t               quo;
	logic              accept;
	logic              last_tri;
	logic              hit_ok;
	logic [CNT_W-1:0]  n_clamp;

	assign accept   = start && !busy;
	assign busy     = state_q != ST_IDLE;
	assign u        = uop(op_q);
	assign fm       = fmul_fin(p_q);
	assign sum      = fadd(acc_q, fm);
	assign last_tri = tri_q == n_q - 1'b1;
	assign n_clamp  = (tc_q > CNT_W'(MAX_TRI)) ? CNT_W'(MAX_TRI) : tc_q;

	// gamma is already known to lie in 0..1 when beta is compared against 1 - gamma.
	assign hit_ok = !t_q[31] && !g_q[31] && (g_q <= FX_ONE) && !b_q[31] &&
	                ($signed({b_q[31], b_q}) <= ($signed({FX_ONE[31], FX_ONE}) -
	                 $signed({g_q[31], g_q}))) && (t_q < best_q);

	always_comb begin
		swr.vert_we    = accept && action == ACT_VERTEX && vertex_sel <= CORNER_LAST;
		swr.mat_we     = accept && action == ACT_MATERIAL;
		swr.slot       = tri_slot;
		swr.corner     = CORNER_LAST - vertex_sel;
		swr.vtx        = '{a_x, a_y, a_z};
		swr.mat.r      = to_channel(a_x);
		swr.mat.g      = to_channel(a_y);
		swr.mat.b      = to_channel(a_z);
		swr.mat.refl   = mirror_flag;
	end

	assign v_re = state_q == ST_ROW;
	assign m_re = state_q == ST_MAT;

	rtnh_store u_store (
		.clk     (clk),
		.wr      (swr),
		.v_re    (v_re),
		.v_raddr (tri_q[SLOT_W-1:0]),
		.v_rdata (v_rdata),
		.m_re    (m_re),
		.m_raddr (bslot_q),
		.m_rdata (m_rdata)
	);

	assign div_start = state_q == ST_DST && rb_q != 0;

	rtnh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ra_q),
		.den    (rb_q),
		.done   (div_done),
		.quo    (quo)
	);

	// Read addresses, and the single write port of the scratch memory.
	always_comb begin
		ra_addr  = u.a;
		rb_addr  = u.b;
		wk_we    = 1'b0;
		wk_waddr = {1'b0, init_q};
		wk_wdata = '0;
		if (state_q == ST_DRD) begin
			rb_addr = WK_DET;
			case (dk_q)
				2'd0:    ra_addr = WK_TN;
				2'd1:    ra_addr = WK_GN;
				default: ra_addr = WK_BN;
			endcase
		end
		if (state_q == ST_INIT) begin
			wk_we = 1'b1;
			// Corner slot 2 of the row is A, 1 is B, 0 is C.
			case (init_q)
				4'd0:    wk_wdata = fsub(v_rdata[2].x, v_rdata[1].x);
				4'd1:    wk_wdata = fsub(v_rdata[2].y, v_rdata[1].y);
				4'd2:    wk_wdata = fsub(v_rdata[2].z, v_rdata[1].z);
				4'd3:    wk_wdata = fsub(v_rdata[2].x, v_rdata[0].x);
				4'd4:    wk_wdata = fsub(v_rdata[2].y, v_rdata[0].y);
				4'd5:    wk_wdata = fsub(v_rdata[2].z, v_rdata[0].z);
				4'd6:    wk_wdata = fsub(v_rdata[2].x, org_q.x);
				4'd7:    wk_wdata = fsub(v_rdata[2].y, org_q.y);
				4'd8:    wk_wdata = fsub(v_rdata[2].z, org_q.z);
				4'd9:    wk_wdata = dir_q.x;
				4'd10:   wk_wdata = dir_q.y;
				4'd11:   wk_wdata = dir_q.z;
				default: wk_wdata = '0;
			endcase
		end else if (state_q == ST_OP && ph_q == 2'd2) begin
			wk_waddr = u.dst;
			case (u.mode)
				OP_SUB:  begin wk_we = 1'b1; wk_wdata = fsub(acc_q, fm); end
				OP_ADDW: begin wk_we = 1'b1; wk_wdata = sum; end
				OP_ADDN: begin wk_we = 1'b1; wk_wdata = fneg(sum); end
				default: wk_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wk_we) begin
			wk_mem[wk_waddr] <= wk_wdata;
		end
		ra_q <= wk_mem[ra_addr];
		rb_q <= wk_mem[rb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tc_q    <= '0;
			done_q  <= 1'b0;
			n_q     <= '0;
			tri_q   <= '0;
			init_q  <= '0;
			op_q    <= '0;
			ph_q    <= '0;
			dk_q    <= '0;
			found_q <= 1'b0;
			bslot_q <= '0;
			best_q  <= FX_MAX;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				tc_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && action == ACT_CAST) begin
						n_q     <= n_clamp;
						tri_q   <= '0;
						found_q <= 1'b0;
						bslot_q <= '0;
						best_q  <= FX_MAX;
						state_q <= (n_clamp == '0) ? ST_MAT : ST_ROW;
					end
				end
				ST_ROW: begin
					init_q  <= '0;
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == 4'd11) begin
						op_q    <= '0;
						ph_q    <= '0;
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						op_q <= op_q + 1'b1;
						if (u.mode == OP_FIRST) begin
							acc_q <= fm;
						end else if (u.mode == OP_ADD) begin
							acc_q <= sum;
						end
						if (op_q == 5'(NUM_UOPS - 1)) begin
							dk_q    <= '0;
							state_q <= ST_DRD;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_DRD: begin
					state_q <= ST_DST;
				end
				ST_DST: begin
					if (rb_q == 0) begin
						// Degenerate triangle: no division, move on.
						tri_q   <= tri_q + 1'b1;
						state_q <= last_tri ? ST_MAT : ST_ROW;
					end else begin
						state_q <= ST_DWT;
					end
				end
				ST_DWT: begin
					if (div_done) begin
						dk_q <= dk_q + 1'b1;
						case (dk_q)
							2'd0:    t_q <= quo;
							2'd1:    g_q <= quo;
							default: b_q <= quo;
						endcase
						state_q <= (dk_q == 2'd2) ? ST_CHK : ST_DRD;
					end
				end
				ST_CHK: begin
					if (hit_ok) begin
						best_q  <= t_q;
						bslot_q <= tri_q[SLOT_W-1:0];
						found_q <= 1'b1;
					end
					tri_q   <= tri_q + 1'b1;
					state_q <= last_tri ? ST_MAT : ST_ROW;
				end
				ST_MAT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OP && ph_q == 2'd1) begin
			p_q <= ra_q * rb_q;
		end
		if (accept && action == ACT_CAST) begin
			org_q <= '{a_x, a_y, a_z};
			dir_q <= '{dir_x, dir_y, dir_z};
		end
		if (state_q == ST_OUT) begin
			hit_q  <= found_q;
			dist_q <= found_q ? best_q[30:0] : '1;
			slot_q <= found_q ? bslot_q : '0;
			mat_q  <= found_q ? m_rdata : '0;
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign hit_distance   = dist_q;
	assign hit_slot       = slot_q;
	assign color_r        = mat_q.r;
	assign color_g        = mat_q.g;
	assign color_b        = mat_q.b;
	assign hit_reflective = mat_q.refl;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while a cast is still running");

	a_nohit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> hit_distance == '1 && hit_slot == '0)
		else $error("no-hit result carries stale fields");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy rose without an accepted item");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> rb_q != '0) else $error("division started with a zero determinant");

endmodule

FILE: sv/rtnh_div.sv
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated and saturated to 32 bits.
// Depends on rtnh_pkg.
module rtnh_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  rtnh_pkg::fx_t num,
	input  rtnh_pkg::fx_t den,
	output logic         done,
	output rtnh_pkg::fx_t quo
);
	import rtnh_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [31:0]       rem_q;
	logic [31:0]       dmag_q;
	logic [DIV_W-1:0]  qsh_q;
	logic              neg_q;
	logic [32:0]       rem_sh;
	logic              ge;
	logic [32:0]       rem_sub;
	logic [31:0]       nmag;

	assign nmag    = num[31] ? 32'(-num) : 32'(num);
	assign rem_sh  = {rem_q, qsh_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dmag_q};
	assign rem_sub = rem_sh - {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dmag_q <= den[31] ? 32'(-den) : 32'(den);
			qsh_q  <= {nmag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			neg_q  <= num[31] ^ den[31];
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			qsh_q <= {qsh_q[DIV_W-2:0], ge};
		end
	end

	always_comb begin
		if (|qsh_q[DIV_W-1:31]) begin
			quo = neg_q ? FX_MIN : FX_MAX;
		end else if (neg_q) begin
			quo = -$signed({1'b0, qsh_q[30:0]});
		end else begin
			quo = $signed({1'b0, qsh_q[30:0]});
		end
	end

	assign done = done_q;

endmodule

FILE: sv/rtnh_store.sv
// Triangle store: vertex rows (three corners per triangle) and materials.
// Synchronous memories with registered reads. Depends on rtnh_pkg.
module rtnh_store (
	input  logic                         clk,
	input  rtnh_pkg::store_wr_t          wr,
	input  logic                         v_re,
	input  logic [rtnh_pkg::SLOT_W-1:0]  v_raddr,
	output rtnh_pkg::vrow_t              v_rdata,
	input  logic                         m_re,
	input  logic [rtnh_pkg::SLOT_W-1:0]  m_raddr,
	output rtnh_pkg::mat_t               m_rdata
);
	import rtnh_pkg::*;

	vrow_t vmem [MAX_TRI];
	mat_t  mmem [MAX_TRI];
	vrow_t v_rd_q;
	mat_t  m_rd_q;

	always_ff @(posedge clk) begin
		if (wr.vert_we) begin
			vmem[wr.slot][wr.corner] <= wr.vtx;
		end
		if (wr.mat_we) begin
			mmem[wr.slot] <= wr.mat;
		end
		if (v_re) begin
			v_rd_q <= vmem[v_raddr];
		end
		if (m_re) begin
			m_rd_q <= mmem[m_raddr];
		end
	end

	assign v_rdata = v_rd_q;
	assign m_rdata = m_rd_q;

endmodule
